@@ rtl/afba_pkg.sv @@
`default_nettype none
package afba_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NO_SPACE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CHECK,
    S_POS_RD,
    S_POS_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } state_t;

  localparam int unsigned MAX_CODE = 6;
  localparam int unsigned WORD_BITS = 32;

  typedef struct packed {
    logic [63:0] name;
    logic [15:0] count;
    logic [2:0]  code;
    logic [14:0] start;
  } extent_t;

endpackage
`default_nettype wire

@@ rtl/aligned_first_fit_bit_allocator_unit.sv @@
`default_nettype none
// Aligned first-fit bit allocator. Each request (name_key, size_code,
// element_count) is checked against a sorted extent table kept in one RAM with
// a single read and a single write port and a registered read, so every lookup
// in a pass goes through a read state and a compare state. One pass over the
// entries checks for a duplicate name and finds the first fitting gap, a check
// state tests the space, a second pass finds the insertion point and the
// entries above it are moved up one slot. A refused request ends sooner, and a
// full table or a bad size code goes straight to the result. ready is low
// meanwhile. The result waits in an output register, and a new result is not
// loaded while the previous one is still waiting.
module aligned_first_fit_bit_allocator_unit #(
  parameter int TABLE_DEPTH  = 256,
  parameter int MAX_DB_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] name_key,
  input  wire logic [3:0]  size_code,
  input  wire logic [15:0] element_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  status,
  output logic      [14:0] bit_handle,
  output logic      [7:0]  slot_index
);
  import afba_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int XW = 25;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam int EW = $bits(extent_t);

  state_t        state, state_next;
  logic [10:0]   db_words;
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] shift_idx, shift_idx_next;
  logic [63:0]   key;
  logic [2:0]    code;
  logic [15:0]   count;
  logic [XW-1:0] handle, handle_next;
  logic [XW-1:0] prev_cand, prev_cand_next;
  logic          found, found_next;
  status_t       res_status, res_status_next;
  logic          load_result;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  extent_t       wdata, rdata;
  logic [EW-1:0] rdata_raw;

  afba_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = extent_t'(rdata_raw);

  logic [XW-1:0] need, ext_end, mask, cand, dbbits, ent_start, gap_lim, handle_end;
  logic [16:0]   words_sat;
  always_comb begin
    need = XW'(count) << code;
    ext_end = XW'(rdata.start) + (XW'(rdata.count) << rdata.code);
    mask = (XW'(1) << code) - XW'(1);
    cand = (ext_end + mask) & ~mask;
    words_sat = (32'(db_words) > 32'(MAX_DB_WORDS)) ? 17'(MAX_DB_WORDS) : 17'(db_words);
    dbbits = XW'(words_sat) * XW'(WORD_BITS);
    ent_start = XW'(rdata.start);
    gap_lim = prev_cand + need;
    handle_end = handle + need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      db_words <= 11'd1024;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      if (cfg_we) db_words <= cfg_wdata;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    shift_idx <= shift_idx_next;
    handle <= handle_next;
    prev_cand <= prev_cand_next;
    found <= found_next;
    res_status <= res_status_next;
    if (in_valid && in_ready) begin
      key <= name_key;
      code <= size_code[2:0];
      count <= element_count;
    end
    if (load_result) begin
      status <= res_status;
      bit_handle <= (res_status == ST_OK) ? handle[14:0] : 15'd0;
      slot_index <= (res_status == ST_OK) ? 8'(idx) : 8'd0;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    used_next = used;
    idx_next = idx;
    shift_idx_next = shift_idx;
    handle_next = handle;
    prev_cand_next = prev_cand;
    found_next = found;
    res_status_next = res_status;
    load_result = 1'b0;
    we = 1'b0;
    waddr = idx[AW-1:0];
    raddr = idx[AW-1:0];
    wdata = rdata;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next = '0;
          found_next = 1'b0;
          handle_next = '0;
          if (used >= DEPTH_C) begin
            res_status_next = ST_FULL;
            state_next = S_DONE;
          end else if (size_code > 4'(MAX_CODE)) begin
            res_status_next = ST_BAD_TYPE;
            state_next = S_DONE;
          end else begin
            res_status_next = ST_OK;
            state_next = (used == '0) ? S_CHECK : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (rdata.name == key) begin
          res_status_next = ST_DUPLICATE;
          state_next = S_DONE;
        end else begin
          prev_cand_next = cand;
          if (!found && idx != '0 && ent_start >= gap_lim) begin
            found_next = 1'b1;
            handle_next = prev_cand;
          end
          if (idx + ONE_C < used) begin
            idx_next = idx + ONE_C;
            state_next = S_SCAN_RD;
          end else begin
            if (!found_next) handle_next = cand;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!found && handle_end > dbbits) begin
          res_status_next = ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          idx_next = '0;
          state_next = S_POS_RD;
        end
      end
      S_POS_RD: begin
        if (idx < used) begin
          state_next = S_POS_CMP;
        end else begin
          shift_idx_next = used;
          state_next = S_SHIFT_RD;
        end
      end
      S_POS_CMP: begin
        if (ent_start <= handle) begin
          idx_next = idx + ONE_C;
          state_next = S_POS_RD;
        end else begin
          shift_idx_next = used;
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        raddr = AW'(shift_idx - ONE_C);
        state_next = (shift_idx > idx) ? S_SHIFT_WR : S_INSERT;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = shift_idx[AW-1:0];
        wdata = rdata;
        shift_idx_next = shift_idx - ONE_C;
        state_next = S_SHIFT_RD;
      end
      S_INSERT: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata.name = key;
        wdata.count = count;
        wdata.code = code;
        wdata.start = handle[14:0];
        used_next = used + ONE_C;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) used <= DEPTH_C)
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (used == $past(used) + ONE_C))
    else $error("insert did not grow table");
  assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SHIFT_WR || state == S_INSERT))
    else $error("stray write");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable({status, bit_handle, slot_index})))
    else $error("result changed while held");
endmodule
`default_nettype wire

@@ rtl/afba_ram.sv @@
`default_nettype none
module afba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
